// File: hdl/lms_pkg.sv
package lms_pkg;

  // Request function codes.
  localparam logic [1:0] FN_LOAD   = 2'd0;
  localparam logic [1:0] FN_FILTER = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;
  localparam logic [1:0] FN_BAD    = 2'd3;

  // Atom kinds.
  localparam logic [1:0] KD_INT = 2'd0;
  localparam logic [1:0] KD_DBL = 2'd1;
  localparam logic [1:0] KD_SYM = 2'd2;
  localparam logic [1:0] KD_BAD = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_STORE,
    ST_EMIT_RD,
    ST_EMIT_CHK,
    ST_EMIT_OUT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic capture;
    logic search;
    logic store;
    logic emit_init;
    logic emit_latch;
    logic emit_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic list_full;
    logic search_done;
    logic item_last;
    logic emit_end;
    logic emit_sel;
  } sts_t;

  // Truncation of a double toward zero, with range and exactness flags.
  typedef struct packed {
    logic        fit;
    logic        integral;
    logic [31:0] val;
  } trunc_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    trunc_t      tr;
  } set_ent_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] value;
    logic        matched;
  } list_ent_t;

  function automatic trunc_t dbl_trunc(input logic [63:0] b);
    trunc_t      r;
    logic [10:0] e;
    logic [10:0] shw;
    logic [5:0]  sh;
    logic [52:0] sig;
    logic [52:0] mag;
    logic [52:0] mask;
    logic [31:0] v;
    e    = b[62:52];
    sig  = {1'b1, b[51:0]};
    shw  = 11'd1075 - e;
    sh   = shw[5:0];
    mag  = sig >> sh;
    mask = ~({53{1'b1}} << sh);
    v    = mag[31:0];
    r    = '0;
    if (e == 11'h7FF) begin
      r = '0;
    end else if (e < 11'd1023) begin
      r.fit      = 1'b1;
      r.integral = (b[62:0] == 63'd0);
    end else if (e <= 11'd1053) begin
      r.fit      = 1'b1;
      r.integral = ((sig & mask) == 53'd0);
      r.val      = b[63] ? (32'd0 - v) : v;
    end else if (e == 11'd1054) begin
      // Only -2^31 truncates into range at this exponent.
      if (b[63] && (b[51:21] == 31'd0)) begin
        r.fit      = 1'b1;
        r.integral = (b[20:0] == 21'd0);
        r.val      = 32'h8000_0000;
      end
    end
    return r;
  endfunction

  function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    return !a_nan && !b_nan &&
           ((a == b) || ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)));
  endfunction

endpackage

// File: hdl/lms_ram.sv
module lms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/lms_ctrl.sv
module lms_ctrl
  import lms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  logic       in_last,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd,
  output logic       in_ready,
  output logic       out_valid
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          priority if (in_func == FN_LOAD) begin
            cmd.load = 1'b1;
          end else if (in_func == FN_CLEAR) begin
            cmd.clear = 1'b1;
          end else if (in_func == FN_FILTER) begin
            if (!sts.list_full) begin
              cmd.capture = 1'b1;
              state_nxt   = ST_SEARCH;
            end else if (in_last) begin
              // Atom dropped, but it still closes the list.
              cmd.emit_init = 1'b1;
              state_nxt     = ST_EMIT_RD;
            end
          end else begin
            // An unused function code is taken and ignored.
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.search_done) begin
          state_nxt = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store = 1'b1;
        if (sts.item_last) begin
          cmd.emit_init = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = sts.emit_end ? ST_FINISH : ST_EMIT_CHK;
      end
      ST_EMIT_CHK: begin
        if (sts.emit_sel) begin
          cmd.emit_latch = 1'b1;
          state_nxt      = ST_EMIT_OUT;
        end else begin
          cmd.emit_next = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end
      end
      ST_EMIT_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_next = 1'b1;
          state_nxt     = ST_EMIT_RD;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/lms_dp.sv
module lms_dp
  import lms_pkg::*;
#(
  parameter int SET_DEPTH  = 256,
  parameter int LIST_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_payload,
  input  logic        in_last,
  output sts_t        sts,
  output logic        out_side,
  output logic [1:0]  out_kind,
  output logic [63:0] out_payload,
  output logic        out_end_of_run
);

  localparam int SAW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int SCW = $clog2(SET_DEPTH + 1);
  localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int LCW = $clog2(LIST_DEPTH + 1);
  localparam int SEW = $bits(set_ent_t);
  localparam int LEW = $bits(list_ent_t);

  // Set bookkeeping.
  logic [SCW-1:0] set_count_r,  set_count_nxt;
  logic [SCW-1:0] load_ptr_r,   load_ptr_nxt;

  // Current filter atom.
  logic [1:0]  fk_r;
  logic [63:0] fv_r;
  logic        flast_r;
  logic        single_r;
  trunc_t      ftr_r;

  // Search.
  logic [SCW-1:0] j_r, j_nxt;
  logic           pend_r, pend_nxt;
  logic           match_r, match_nxt;

  // List buffer bookkeeping.
  logic [LCW-1:0] list_count_r, list_count_nxt;
  logic           any_match_r,  any_match_nxt;
  logic [LAW-1:0] last_match_r;
  logic [LCW-1:0] e_r, e_nxt;
  logic [LCW-1:0] last_emit;

  trunc_t    in_tr;
  set_ent_t  set_wr;
  set_ent_t  set_rd;
  logic      set_we;
  logic [SEW-1:0] set_rd_bits;
  list_ent_t list_wr;
  list_ent_t list_rd;
  logic [LEW-1:0] list_rd_bits;
  logic      hit;

  assign in_tr = dbl_trunc(in_payload);

  // Integer entries are kept as their exact value, which makes every
  // mixed compare an integer compare on the truncation flags.
  always_comb begin
    set_wr.kind  = in_kind;
    set_wr.value = in_payload;
    if (in_kind == KD_INT) begin
      set_wr.tr.fit      = 1'b1;
      set_wr.tr.integral = 1'b1;
      set_wr.tr.val      = in_payload[31:0];
    end else begin
      set_wr.tr = in_tr;
    end
  end

  assign set_we = cmd.load && (in_kind != KD_BAD) && (load_ptr_r < SCW'(SET_DEPTH));

  lms_ram #(.WIDTH(SEW), .DEPTH(SET_DEPTH)) u_set_ram (
    .clk     (clk),
    .we      (set_we),
    .waddr   (load_ptr_r[SAW-1:0]),
    .wdata   (set_wr),
    .raddr   (j_r[SAW-1:0]),
    .rd_data (set_rd_bits)
  );

  assign set_rd = set_ent_t'(set_rd_bits);

  always_comb begin
    hit = 1'b0;
    unique case (fk_r)
      KD_SYM: hit = (set_rd.kind == KD_SYM) && (set_rd.value == fv_r);
      KD_INT: hit = (set_rd.kind != KD_SYM) && set_rd.tr.fit &&
                    (single_r || set_rd.tr.integral) &&
                    (set_rd.tr.val == fv_r[31:0]);
      KD_DBL: begin
        if (set_rd.kind == KD_DBL) begin
          hit = dbl_eq(set_rd.value, fv_r);
        end else if (set_rd.kind == KD_INT) begin
          hit = ftr_r.fit && ftr_r.integral && (ftr_r.val == set_rd.tr.val);
        end
      end
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    set_count_nxt  = set_count_r;
    load_ptr_nxt   = load_ptr_r;
    j_nxt          = j_r;
    pend_nxt       = 1'b0;
    match_nxt      = match_r;
    list_count_nxt = list_count_r;
    any_match_nxt  = any_match_r;
    e_nxt          = e_r;
    if (cmd.load) begin
      if (set_we) begin
        load_ptr_nxt  = load_ptr_r + 1'b1;
        set_count_nxt = load_ptr_r + 1'b1;
      end
      if (in_last) begin
        load_ptr_nxt = '0;
      end
    end
    if (cmd.clear) begin
      set_count_nxt = '0;
      load_ptr_nxt  = '0;
    end
    if (cmd.capture) begin
      j_nxt     = '0;
      match_nxt = 1'b0;
    end
    if (cmd.search) begin
      if (j_r < set_count_r) begin
        j_nxt    = j_r + 1'b1;
        pend_nxt = 1'b1;
      end
      if (pend_r && hit) begin
        match_nxt = 1'b1;
      end
    end
    if (cmd.store) begin
      list_count_nxt = list_count_r + 1'b1;
      if (match_r) begin
        any_match_nxt = 1'b1;
      end
    end
    if (cmd.emit_init) begin
      e_nxt = '0;
    end
    if (cmd.emit_next) begin
      e_nxt = e_r + 1'b1;
    end
    if (cmd.finish) begin
      list_count_nxt = '0;
      any_match_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_count_r  <= '0;
      load_ptr_r   <= '0;
      list_count_r <= '0;
      any_match_r  <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      set_count_r  <= set_count_nxt;
      load_ptr_r   <= load_ptr_nxt;
      list_count_r <= list_count_nxt;
      any_match_r  <= any_match_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    match_r <= match_nxt;
    e_r     <= e_nxt;
    if (cmd.capture) begin
      fk_r     <= in_kind;
      fv_r     <= in_payload;
      flast_r  <= in_last;
      single_r <= in_last && (list_count_r == '0) && (in_kind == KD_INT);
      ftr_r    <= in_tr;
    end
    if (cmd.store && match_r) begin
      last_match_r <= list_count_r[LAW-1:0];
    end
  end

  assign list_wr.kind    = fk_r;
  assign list_wr.value   = fv_r;
  assign list_wr.matched = match_r;

  lms_ram #(.WIDTH(LEW), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk     (clk),
    .we      (cmd.store),
    .waddr   (list_count_r[LAW-1:0]),
    .wdata   (list_wr),
    .raddr   (e_r[LAW-1:0]),
    .rd_data (list_rd_bits)
  );

  assign list_rd = list_ent_t'(list_rd_bits);

  assign last_emit = any_match_r ? LCW'(last_match_r) : (list_count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.emit_latch) begin
      out_side       <= !any_match_r;
      out_kind       <= list_rd.kind;
      out_payload    <= list_rd.value;
      out_end_of_run <= (e_r == last_emit);
    end
  end

  assign sts.list_full   = (list_count_r == LCW'(LIST_DEPTH));
  assign sts.search_done = (j_r == set_count_r) && !pend_r;
  assign sts.item_last   = flast_r;
  assign sts.emit_end    = (e_r == list_count_r);
  assign sts.emit_sel    = !any_match_r || list_rd.matched;

endmodule

// File: hdl/list_membership_sieve.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_func, in_kind, in_payload, in_last
// out_      output     out_valid / out_ready  out_side, out_kind, out_payload,
//                                             out_end_of_run
//
// A load or clear request is completed on acceptance. A filter request is accepted,
// then searched for in the set through the registered set memory read port, and
// then the atom is buffered. At list end every buffered atom is read and
// inspected, each emitted one is held until out_ready, and a closing step clears
// the list.
// Reset is synchronous and clears the state, the counters and the flags only; the
// memories need no clearing pass since entries are only read below the counts.
// in_ready is low while a search or an emission is in progress.
module list_membership_sieve
  import lms_pkg::*;
#(
  parameter int SET_DEPTH  = 256,
  parameter int LIST_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_payload,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_side,
  output logic [1:0]  out_kind,
  output logic [63:0] out_payload,
  output logic        out_end_of_run
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences search, buffering and emission.
  lms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_last   (in_last),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid)
  );

  // The datapath holds the set memory, the list buffer and the compare logic.
  lms_dp #(
    .SET_DEPTH  (SET_DEPTH),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_kind        (in_kind),
    .in_payload     (in_payload),
    .in_last        (in_last),
    .sts            (sts),
    .out_side       (out_side),
    .out_kind       (out_kind),
    .out_payload    (out_payload),
    .out_end_of_run (out_end_of_run)
  );

endmodule

// File: hdl/lms_checker.sv
module lms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_payload,
  input logic        out_end_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result right after a request");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_end_of_run |=> !in_ready)
    else $error("emission ended before end of run");

endmodule

bind list_membership_sieve lms_checker u_lms_checker (.*);
